// File: design/fm_register_harmonic_transposer_unit_defines.svh
// Assertion macros shared by the transposer RTL.
// Both sample on clk and are disabled while rst_n is low.
`ifndef FM_REGISTER_HARMONIC_TRANSPOSER_UNIT_DEFINES_SVH
`define FM_REGISTER_HARMONIC_TRANSPOSER_UNIT_DEFINES_SVH

// same-cycle implication
`define FMHT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FMHT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/fmht_pkg.sv
package fmht_pkg;

  // shadow storage: one row per channel, {B byte, A byte}
  localparam int ROWS     = 16;
  localparam int ROW_W    = 16;
  localparam int CH_W     = $clog2(ROWS);

  localparam int GAIN_W   = 17;
  localparam int FNUM_W   = 10;
  localparam int BLK_W    = 3;
  localparam int PROD_W   = GAIN_W + FNUM_W;
  localparam int FRAC_W   = 16;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65707);

  localparam int FNUM_MAX   = 1023;
  localparam int FNUM_FLOOR = 32;
  localparam logic [PROD_W-1:0] THR_HI = PROD_W'((FNUM_MAX - FNUM_FLOOR) << FRAC_W);
  localparam logic [PROD_W-1:0] THR_LO = PROD_W'(FNUM_FLOOR << FRAC_W);
  localparam logic [BLK_W-1:0]  BLK_TOP = '1;

  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FREQ_GAIN = 1'b0,
    CFG_OPL3_MODE = 1'b1
  } cfg_idx_t;

  localparam logic [3:0] GRP_FNUM  = 4'hA;
  localparam logic [3:0] GRP_BLOCK = 4'hB;
  localparam logic [3:0] GRP_CTRL  = 4'hC;
  localparam logic [3:0] NIB_PERC_MAX = 4'h5;
  localparam logic [3:0] NIB_CH_MAX   = 4'h8;
  localparam logic [7:0] REG_PERC  = 8'hBD;
  localparam logic [7:0] REG_OPL3_A = 8'h04;
  localparam logic [7:0] REG_OPL3_B = 8'h05;
  localparam logic [7:0] PAN_LEFT  = 8'h10;
  localparam logic [7:0] PAN_RIGHT = 8'h20;
  localparam logic [7:0] PAN_BOTH  = 8'h30;
  localparam int         PERC_BIT  = 5;

  localparam logic TGT_PRIMARY   = 1'b0;
  localparam logic TGT_SECONDARY = 1'b1;
  localparam logic BANK_LOW      = 1'b0;
  localparam logic BANK_HIGH     = 1'b1;

  localparam int MAX_RES   = 3;
  localparam int RES_CNT_W = 2;
  localparam int OB_DEPTH  = 4;
  localparam int OB_IDX_W  = $clog2(OB_DEPTH);
  localparam int OB_CNT_W  = $clog2(OB_DEPTH + 1);

  typedef struct packed {
    logic       target;
    logic [8:0] address;
    logic [7:0] data;
    logic       last;
  } result_t;

  typedef struct packed {
    logic                     valid;
    logic [RES_CNT_W-1:0]     count;
    result_t [MAX_RES-1:0]    res;
  } load_t;

  typedef struct packed {
    logic [BLK_W-1:0]  blk;
    logic [FNUM_W-1:0] fnum;
  } tune_t;

  function automatic tune_t retune_calc(input logic [PROD_W-1:0] p,
                                        input logic [BLK_W-1:0]  blk,
                                        input logic [FNUM_W-1:0] fnum);
    tune_t t;
    t.blk  = blk;
    t.fnum = fnum;
    if (p > THR_HI) begin
      if (blk != BLK_TOP) begin
        t.blk  = blk + BLK_W'(1);
        t.fnum = p[FRAC_W+1 +: FNUM_W];
      end
    end else if (p < THR_LO) begin
      if (blk != '0) begin
        t.blk  = blk - BLK_W'(1);
        t.fnum = p[FRAC_W-1 +: FNUM_W];
      end
    end else begin
      t.fnum = p[FRAC_W +: FNUM_W];
    end
    // every branch yields at most 1023, so the range fallback never fires
    return t;
  endfunction

endpackage

// File: design/fmht_in_if.sv
interface fmht_in_if;
  import fmht_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] reg_address;
  logic [7:0] reg_data;

  modport source (output valid, output reg_address, output reg_data, input ready);
  modport sink   (input valid, input reg_address, input reg_data, output ready);
endinterface

// File: design/fmht_out_if.sv
interface fmht_out_if;
  import fmht_pkg::*;

  logic       valid;
  logic       ready;
  logic       out_target;
  logic [8:0] out_address;
  logic [7:0] out_data;
  logic       out_last;

  modport source (output valid, output out_target, output out_address, output out_data,
                  output out_last, input ready);
  modport sink   (input valid, input out_target, input out_address, input out_data,
                  input out_last, output ready);
endinterface

// File: design/fmht_ram.sv
module fmht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read-first on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// File: design/fmht_outbuf.sv
`include "fm_register_harmonic_transposer_unit_defines.svh"

module fmht_outbuf (
  input  logic            clk,
  input  logic            rst_n,
  input  fmht_pkg::load_t ld,
  output logic            room,
  fmht_out_if.source      out_ch
);
  import fmht_pkg::*;

  result_t               q_r   [OB_DEPTH];
  result_t               q_nxt [OB_DEPTH];
  logic [OB_CNT_W-1:0]   cnt_r;
  logic [OB_CNT_W-1:0]   cnt_nxt;
  logic                  xfer;

  assign xfer = out_ch.valid && out_ch.ready;
  assign room = (cnt_r <= OB_CNT_W'(1));

  always_comb begin
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (xfer) begin
      for (int i = 0; i < OB_DEPTH - 1; i++) begin
        q_nxt[i] = q_r[i+1];
      end
      cnt_nxt = cnt_r - OB_CNT_W'(1);
    end
    if (ld.valid) begin
      for (int j = 0; j < MAX_RES; j++) begin
        if (RES_CNT_W'(j) < ld.count) begin
          q_nxt[cnt_nxt[OB_IDX_W-1:0] + OB_IDX_W'(j)] = ld.res[j];
        end
      end
      cnt_nxt = cnt_nxt + OB_CNT_W'(ld.count);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign out_ch.valid       = (cnt_r != '0);
  assign out_ch.out_target  = q_r[0].target;
  assign out_ch.out_address = q_r[0].address;
  assign out_ch.out_data    = q_r[0].data;
  assign out_ch.out_last    = q_r[0].last;

  `FMHT_ASSERT_IMP(a_tail_is_last, cnt_r != '0, q_r[cnt_r[OB_IDX_W-1:0] - OB_IDX_W'(1)].last, "queue tail not marked last")
  `FMHT_ASSERT_IMP(a_load_has_room, ld.valid, cnt_r <= OB_CNT_W'(1) && ld.count != '0, "load without room")
endmodule

// File: design/fm_register_harmonic_transposer_unit.sv
// A taken write is registered in stage 1, then in stage 2, then in the output queue before its first
// output transfer is offered; further outputs of the same write follow one per cycle while out_ch is ready.
// Throughput: one write per cycle when each yields one output and out_ch is ready;
// a frequency write is held while one to the same channel is still in stage 1 or stage 2.
// Reset clears the pipeline, the output queue, percussion and the shadow row valid bits
// and restores the config defaults; shadow memories are not swept.
`include "fm_register_harmonic_transposer_unit_defines.svh"

module fm_register_harmonic_transposer_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fmht_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fmht_pkg::GAIN_W-1:0]    cfg_wdata,
  fmht_in_if.sink                        in_ch,
  fmht_out_if.source                     out_ch
);
  import fmht_pkg::*;

  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] data;
    logic       melodic;
    logic       retune;
    logic       copy_up;
  } stage_t;

  // config
  logic [GAIN_W-1:0] gain_r;
  logic              opl3_r;
  logic              perc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
      opl3_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FREQ_GAIN: gain_r <= cfg_wdata;
        CFG_OPL3_MODE: opl3_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // accept stage
  logic [3:0]  in_grp;
  logic [3:0]  in_nib;
  logic        in_freq;
  stage_t      in_st;
  logic        in_xfer;
  logic        hazard;

  logic        s1_vld_r, s2_vld_r;
  stage_t      s1_r, s2_r;
  logic        s1_adv, s2_adv;
  logic        room;

  assign in_grp  = in_ch.reg_address[7:4];
  assign in_nib  = in_ch.reg_address[3:0];
  assign in_freq = (in_grp == GRP_FNUM) || (in_grp == GRP_BLOCK);

  always_comb begin
    in_st.addr    = in_ch.reg_address;
    in_st.data    = in_ch.reg_data;
    in_st.melodic = (in_nib <= NIB_PERC_MAX) || !perc_r;
    in_st.retune  = in_freq && in_st.melodic && (in_ch.reg_address != REG_PERC);
    in_st.copy_up = (in_ch.reg_address != REG_OPL3_A) && (in_ch.reg_address != REG_OPL3_B) &&
                    !in_freq && (!perc_r || !in_grp[0]);
  end

  // rows still being modified ahead of this one lock the channel
  assign hazard = in_st.retune &&
                  ((s1_vld_r && s1_r.retune && (s1_r.addr[3:0] == in_nib)) ||
                   (s2_vld_r && s2_r.retune && (s2_r.addr[3:0] == in_nib)));

  assign s2_adv      = s2_vld_r && room;
  assign s1_adv      = s1_vld_r && (!s2_vld_r || s2_adv);
  assign in_ch.ready = (!s1_vld_r || s1_adv) && !hazard;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      perc_r <= 1'b0;
    end else if (in_xfer && (in_ch.reg_address == REG_PERC)) begin
      perc_r <= in_ch.reg_data[PERC_BIT];
    end
  end

  // shadow memories
  logic [ROWS-1:0]  ovld_r, svld_r;
  logic             s1_ov_r, s1_sv_r;
  logic [ROW_W-1:0] orig_rd, shf_rd;
  logic             orig_we, shf_we;
  logic [ROW_W-1:0] orig_wd, shf_wd;

  fmht_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_orig_ram (
    .clk   (clk),
    .we    (orig_we),
    .waddr (s2_r.addr[CH_W-1:0]),
    .wdata (orig_wd),
    .re    (in_xfer),
    .raddr (in_nib),
    .rdata (orig_rd)
  );

  fmht_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_shf_ram (
    .clk   (clk),
    .we    (shf_we),
    .waddr (s2_r.addr[CH_W-1:0]),
    .wdata (shf_wd),
    .re    (in_xfer),
    .raddr (in_nib),
    .rdata (shf_rd)
  );

  // stage 1: merge write into original row, multiply
  logic [ROW_W-1:0]  s1_orow, s1_srow;
  logic [7:0]        s1_hi;
  logic [FNUM_W-1:0] s1_fnum;
  logic [PROD_W-1:0] s1_p;

  always_comb begin
    s1_orow = s1_ov_r ? orig_rd : '0;
    s1_srow = s1_sv_r ? shf_rd : '0;
    if (s1_r.addr[4]) begin
      s1_orow[15:8] = s1_r.data;
    end else begin
      s1_orow[7:0] = s1_r.data;
    end
    s1_hi   = s1_orow[15:8];
    s1_fnum = {s1_hi[1:0], s1_orow[7:0]};
    s1_p    = PROD_W'(s1_fnum) * PROD_W'(gain_r);
  end

  logic [ROW_W-1:0]  s2_orow_r, s2_srow_r;
  logic [PROD_W-1:0] s2_p_r;
  logic [BLK_W-1:0]  s2_blk_r;
  logic [FNUM_W-1:0] s2_fnum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      ovld_r   <= '0;
      svld_r   <= '0;
    end else begin
      if (in_xfer) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_vld_r <= 1'b1;
      end else if (s2_adv) begin
        s2_vld_r <= 1'b0;
      end
      if (orig_we) begin
        ovld_r[s2_r.addr[CH_W-1:0]] <= 1'b1;
      end
      if (shf_we) begin
        svld_r[s2_r.addr[CH_W-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_r    <= in_st;
      s1_ov_r <= ovld_r[in_nib];
      s1_sv_r <= svld_r[in_nib];
    end
    if (s1_adv) begin
      s2_r      <= s1_r;
      s2_orow_r <= s1_orow;
      s2_srow_r <= s1_srow;
      s2_p_r    <= s1_p;
      s2_blk_r  <= s1_hi[4:2];
      s2_fnum_r <= s1_fnum;
    end
  end

  // stage 2: retune, write back, form outputs
  tune_t      t;
  logic       rmw, is_b, pair_chg;
  logic [7:0] new_a, new_b, nb0, own_out, pair_out;
  logic [7:0] pair_addr;

  always_comb begin
    t        = retune_calc(s2_p_r, s2_blk_r, s2_fnum_r);
    is_b     = s2_r.addr[4];
    rmw      = s2_r.retune && (s2_r.addr[3:0] <= NIB_CH_MAX);
    new_a    = t.fnum[7:0];
    nb0      = {s2_orow_r[15:13], t.blk, t.fnum[9:8]};
    if (is_b) begin
      new_b    = {s2_r.data[7:5], t.blk, t.fnum[9:8]};
      pair_chg = (s2_srow_r[7:0] != new_a);
    end else begin
      pair_chg = nb0[PERC_BIT] && (s2_srow_r[15:8] != nb0);
      new_b    = pair_chg ? nb0 : s2_srow_r[15:8];
    end
    pair_chg  = pair_chg && rmw;
    own_out   = rmw ? (is_b ? new_b : new_a) : (is_b ? s2_srow_r[15:8] : s2_srow_r[7:0]);
    pair_out  = is_b ? new_a : new_b;
    pair_addr = {s2_r.addr[7:5], ~s2_r.addr[4], s2_r.addr[3:0]};
  end

  assign orig_we = s2_adv && s2_r.retune;
  assign orig_wd = s2_orow_r;
  assign shf_we  = s2_adv && rmw;
  assign shf_wd  = {new_b, new_a};

  function automatic result_t mk(input logic tgt, input logic bank, input logic [7:0] addr,
                                 input logic [7:0] data);
    result_t r;
    r.target  = tgt;
    r.address = {bank, addr};
    r.data    = data;
    r.last    = 1'b0;
    return r;
  endfunction

  result_t [MAX_RES-1:0] res;
  logic [RES_CNT_W-1:0]  n;
  load_t                 ld;

  always_comb begin
    res = '0;
    n   = '0;
    if (!opl3_r) begin
      res[n] = mk(TGT_PRIMARY, BANK_LOW, s2_r.addr, s2_r.data);
      n = n + RES_CNT_W'(1);
      if (s2_r.retune) begin
        if (pair_chg) begin
          res[n] = mk(TGT_SECONDARY, BANK_LOW, pair_addr, pair_out);
          n = n + RES_CNT_W'(1);
        end
        res[n] = mk(TGT_SECONDARY, BANK_LOW, s2_r.addr, own_out);
      end else begin
        res[n] = mk(TGT_SECONDARY, BANK_LOW, s2_r.addr, s2_r.data);
      end
      n = n + RES_CNT_W'(1);
    end else begin
      if (s2_r.addr[7:4] == GRP_CTRL) begin
        if (s2_r.melodic) begin
          res[n] = mk(TGT_PRIMARY, BANK_LOW, s2_r.addr, s2_r.data | PAN_LEFT);
          n = n + RES_CNT_W'(1);
          res[n] = mk(TGT_PRIMARY, BANK_HIGH, s2_r.addr, s2_r.data | PAN_RIGHT);
        end else begin
          res[n] = mk(TGT_PRIMARY, BANK_LOW, s2_r.addr, s2_r.data | PAN_BOTH);
        end
        n = n + RES_CNT_W'(1);
      end else begin
        res[n] = mk(TGT_PRIMARY, BANK_LOW, s2_r.addr, s2_r.data);
        n = n + RES_CNT_W'(1);
        if (s2_r.copy_up) begin
          res[n] = mk(TGT_PRIMARY, BANK_HIGH, s2_r.addr, s2_r.data);
          n = n + RES_CNT_W'(1);
        end
      end
      if (s2_r.retune) begin
        if (pair_chg) begin
          res[n] = mk(TGT_PRIMARY, BANK_HIGH, pair_addr, pair_out);
          n = n + RES_CNT_W'(1);
        end
        res[n] = mk(TGT_PRIMARY, BANK_HIGH, s2_r.addr, own_out);
        n = n + RES_CNT_W'(1);
      end
    end
    res[n - RES_CNT_W'(1)].last = 1'b1;
    ld.valid = s2_adv;
    ld.count = n;
    ld.res   = res;
  end

  fmht_outbuf u_outbuf (
    .clk    (clk),
    .rst_n  (rst_n),
    .ld     (ld),
    .room   (room),
    .out_ch (out_ch)
  );

  `FMHT_ASSERT_IMP(a_row_exclusive, s1_vld_r && s2_vld_r && s1_r.retune && s2_r.retune, s1_r.addr[3:0] != s2_r.addr[3:0], "two row updates in flight")
  `FMHT_ASSERT_NXT(a_s1_holds, s1_vld_r && !s1_adv, s1_vld_r && $stable(s1_r), "stage 1 lost while stalled")
  `FMHT_ASSERT_IMP(a_no_read_on_write, in_xfer && in_st.retune && (orig_we || shf_we), s2_r.addr[3:0] != in_nib, "row read during its write")
endmodule

// File: test/tb_fm_register_harmonic_transposer_unit.sv
module tb_fm_register_harmonic_transposer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import fmht_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GAIN_W-1:0] cfg_wdata;

  fmht_in_if in_if ();
  fmht_out_if out_if ();

  fm_register_harmonic_transposer_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  // {reg_address, reg_data} still to be sent
  logic [15:0] reg_writes_todo[$];
  // chip writes predicted, oldest first
  result_t chip_writes_due[$];

  int unsigned gap_pct;
  int unsigned stall_pct;
  int errors;

  // mirror of the block's configuration and shadow state
  logic [GAIN_W-1:0] gain_m;
  logic opl3_m;
  logic [7:0] orig_sh[32];
  logic [7:0] tuned_sh[32];
  logic perc_m;

  always #5 clk = ~clk;

  function automatic void emit(logic tgt, logic [8:0] a, logic [7:0] d);
    result_t r;
    r.target = tgt;
    r.address = a;
    r.data = d;
    r.last = 1'b0;
    chip_writes_due.push_back(r);
  endfunction

  // updates the shadows; returns 1 when the paired register changes
  function automatic bit retune(logic [7:0] a, logic [7:0] d);
    logic [3:0] ch;
    logic [7:0] hi;
    logic [7:0] nb0;
    logic [2:0] blk;
    logic [2:0] nb;
    logic [9:0] fnum;
    logic [16:0] nf;
    logic [PROD_W-1:0] p;
    ch = a[3:0];
    orig_sh[a[4:0]] = d;
    hi = orig_sh[{1'b1, ch}];
    blk = hi[4:2];
    fnum = {hi[1:0], orig_sh[{1'b0, ch}]};
    p = PROD_W'(fnum) * PROD_W'(gain_m);
    nb = blk;
    if (p > PROD_W'((FNUM_MAX - FNUM_FLOOR) << 16)) begin
      if (blk == 3'd7) begin
        nf = 17'(fnum);
      end else begin
        nb = blk + 3'd1;
        nf = 17'(p >> 17);
      end
    end else if (p < PROD_W'(FNUM_FLOOR << 16)) begin
      if (blk == 3'd0) begin
        nf = 17'(fnum);
      end else begin
        nb = blk - 3'd1;
        nf = 17'(p >> 15);
      end
    end else begin
      nf = 17'(p >> 16);
    end
    if (nf > 17'(FNUM_MAX)) begin
      nb = blk;
      nf = 17'(fnum);
    end
    if (a[3:0] <= NIB_CH_MAX && a[7:4] == GRP_BLOCK) begin
      tuned_sh[a[4:0]] = {d[7:5], nb, nf[9:8]};
      if (tuned_sh[{1'b0, ch}] != nf[7:0]) begin
        tuned_sh[{1'b0, ch}] = nf[7:0];
        return 1'b1;
      end
    end else if (a[3:0] <= NIB_CH_MAX && a[7:4] == GRP_FNUM) begin
      tuned_sh[a[4:0]] = nf[7:0];
      nb0 = {orig_sh[{1'b1, ch}][7:5], nb, nf[9:8]};
      if (nb0[5] && tuned_sh[{1'b1, ch}] != nb0) begin
        tuned_sh[{1'b1, ch}] = nb0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void transpose_write(logic [7:0] a, logic [7:0] d);
    logic [3:0] grp;
    logic [7:0] pr;
    bit fgrp;
    bit mel;
    result_t r;
    grp = a[7:4];
    fgrp = (grp == GRP_FNUM) || (grp == GRP_BLOCK);
    mel = (a[3:0] <= NIB_PERC_MAX) || !perc_m;
    pr = (grp == GRP_FNUM) ? a + 8'h10 : a - 8'h10;
    if (!opl3_m) begin
      emit(TGT_PRIMARY, {BANK_LOW, a}, d);
      if (a == REG_PERC) begin
        perc_m = d[PERC_BIT];
        emit(TGT_SECONDARY, {BANK_LOW, a}, d);
      end else if (fgrp && mel) begin
        if (retune(a, d)) emit(TGT_SECONDARY, {BANK_LOW, pr}, tuned_sh[pr[4:0]]);
        emit(TGT_SECONDARY, {BANK_LOW, a}, tuned_sh[a[4:0]]);
      end else begin
        emit(TGT_SECONDARY, {BANK_LOW, a}, d);
      end
    end else begin
      if (grp == GRP_CTRL) begin
        if (mel) begin
          emit(TGT_PRIMARY, {BANK_LOW, a}, d | PAN_LEFT);
          emit(TGT_PRIMARY, {BANK_HIGH, a}, d | PAN_RIGHT);
        end else begin
          emit(TGT_PRIMARY, {BANK_LOW, a}, d | PAN_BOTH);
        end
      end else begin
        emit(TGT_PRIMARY, {BANK_LOW, a}, d);
        if (a != REG_OPL3_A && a != REG_OPL3_B && !fgrp && (!perc_m || !grp[0]))
          emit(TGT_PRIMARY, {BANK_HIGH, a}, d);
      end
      if (a == REG_PERC) begin
        perc_m = d[PERC_BIT];
      end else if (fgrp && mel) begin
        if (retune(a, d)) emit(TGT_PRIMARY, {BANK_HIGH, pr}, tuned_sh[pr[4:0]]);
        emit(TGT_PRIMARY, {BANK_HIGH, a}, tuned_sh[a[4:0]]);
      end
    end
    r = chip_writes_due.pop_back();
    r.last = 1'b1;
    chip_writes_due.push_back(r);
  endfunction

  function automatic logic [15:0] rand_write();
    logic [7:0] a;
    logic [3:0] ch;
    int unsigned pick;
    pick = $urandom_range(99);
    ch = $urandom_range(1) ? 4'($urandom_range(2)) : 4'($urandom_range(8));
    if ($urandom_range(7) == 0) ch = 4'($urandom_range(15));
    if (pick < 60) a = {$urandom_range(1) ? GRP_BLOCK : GRP_FNUM, ch};
    else if (pick < 68) a = REG_PERC;
    else if (pick < 78) a = {GRP_CTRL, 4'($urandom_range(15))};
    else if (pick < 83) a = $urandom_range(1) ? REG_OPL3_A : REG_OPL3_B;
    else a = 8'($urandom);
    return {a, 8'($urandom)};
  endfunction

  task automatic queue_write(logic [7:0] a, logic [7:0] d);
    reg_writes_todo.push_back({a, d});
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [GAIN_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_FREQ_GAIN) gain_m = val;
    else opl3_m = val[0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (reg_writes_todo.size() != 0 || in_if.valid || chip_writes_due.size() != 0);
    repeat (6) @(negedge clk);
  endtask

  always @(posedge clk) begin : driver
    logic [15:0] w;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) transpose_write(in_if.reg_address, in_if.reg_data);
      if (!in_if.valid || in_if.ready) begin
        if (reg_writes_todo.size() != 0 && $urandom_range(99) >= gap_pct) begin
          w = reg_writes_todo.pop_front();
          in_if.valid <= 1'b1;
          in_if.reg_address <= w[15:8];
          in_if.reg_data <= w[7:0];
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (chip_writes_due.size() == 0) begin
          $error("unexpected transfer: address %h data %h", out_if.out_address, out_if.out_data);
          errors++;
        end else begin
          want = chip_writes_due.pop_front();
          if (out_if.out_target !== want.target) begin
            $error("out_target: expected %0d, got %0d", want.target, out_if.out_target);
            errors++;
          end
          if (out_if.out_address !== want.address) begin
            $error("out_address: expected %h, got %h", want.address, out_if.out_address);
            errors++;
          end
          if (out_if.out_data !== want.data) begin
            $error("out_data: expected %h, got %h", want.data, out_if.out_data);
            errors++;
          end
          if (out_if.out_last !== want.last) begin
            $error("out_last: expected %0d, got %0d", want.last, out_if.out_last);
            errors++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [GAIN_W-1:0] gain;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_FREQ_GAIN;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.reg_address = '0;
    in_if.reg_data = '0;
    out_if.ready = 1'b0;
    gap_pct = 0;
    stall_pct = 0;
    errors = 0;
    gain_m = GAIN_RESET;
    opl3_m = 1'b0;
    perc_m = 1'b0;
    for (int i = 0; i < 32; i++) begin
      orig_sh[i] = '0;
      tuned_sh[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // two-chip mode, reset gain
    queue_write(8'h00, 8'h00);
    queue_write(8'hFF, 8'hFF);
    queue_write(8'hA0, 8'hFF);
    queue_write(8'hB0, 8'h3F);  // top block, no room to go up
    queue_write(8'hB0, 8'h23);  // block 0 overflows into block 1
    queue_write(8'hA1, 8'h05);
    queue_write(8'hB1, 8'h24);  // low F-number drops a block
    queue_write(8'hA2, 8'h10);
    queue_write(8'hB2, 8'h20);  // low F-number stuck at block 0
    queue_write(REG_PERC, 8'h20);
    queue_write(8'hA7, 8'h80);  // percussion channel
    queue_write(8'hB7, 8'h31);
    queue_write(8'hA9, 8'h12);  // beyond channel 8
    queue_write(8'hBF, 8'h55);
    queue_write(REG_PERC, 8'h00);
    drain();

    write_reg(CFG_OPL3_MODE, GAIN_W'(1));
    @(negedge clk);
    queue_write(8'hC0, 8'h00);
    queue_write(REG_OPL3_A, 8'hFF);
    queue_write(REG_OPL3_B, 8'h01);
    queue_write(8'h20, 8'h01);
    queue_write(8'hA0, 8'h40);
    queue_write(8'hB0, 8'h2A);
    queue_write(REG_PERC, 8'h20);
    queue_write(8'hC6, 8'h0F);
    queue_write(8'h36, 8'h11);
    queue_write(8'hA6, 8'h10);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: gain = GAIN_W'(131071);
        1: gain = GAIN_W'(0);
        2: gain = GAIN_W'(65536);
        3: gain = GAIN_RESET;
        5: gain = GAIN_W'(40000);
        6: gain = GAIN_W'(120000);
        default: gain = GAIN_W'($urandom);
      endcase
      write_reg(CFG_FREQ_GAIN, gain);
      write_reg(CFG_OPL3_MODE, GAIN_W'(ph % 3 == 1 || ph == 4));
      @(negedge clk);
      case (ph % 4)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 72; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 72; end
        default: begin gap_pct = 24; stall_pct = 24; end
      endcase
      for (int i = 0; i < 30; i++) reg_writes_todo.push_back(rand_write());
      drain();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: fm_register_harmonic_transposer_unit.f
+incdir+design
design/fmht_pkg.sv
design/fmht_in_if.sv
design/fmht_out_if.sv
design/fmht_ram.sv
design/fmht_outbuf.sv
design/fm_register_harmonic_transposer_unit.sv
test/tb_fm_register_harmonic_transposer_unit.sv
